// ===== sv/cst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_pkg: shared types and constants for the source tokenizer
// Beat structs, class codes, character codes and the keyword tables.
// ----------------------------------------------------------------------------
package cst_pkg;

  // longest token length counted before saturation
  localparam int MAX_TOKEN_CHARS_DEF = 128;

  // number of leading characters kept for keyword matching
  localparam int PREFIX_CHARS = 8;
  localparam int KW_COUNT     = 9;

  // input beat kind codes
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // token class codes
  localparam logic [2:0] CLS_IDENT   = 3'd0;
  localparam logic [2:0] CLS_KEYWORD = 3'd1;
  localparam logic [2:0] CLS_CONST   = 3'd2;
  localparam logic [2:0] CLS_PUNCT   = 3'd5;
  localparam logic [2:0] CLS_PREPROC = 3'd6;
  localparam logic [2:0] CLS_UNKNOWN = 3'd7;

  // character codes
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LT     = 8'h3c;
  localparam logic [7:0] CH_GT     = 8'h3e;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_UNDER  = 8'h5f;

  // keyword text, first character in slot 0, unused slots zero
  localparam logic [0:KW_COUNT-1][0:PREFIX_CHARS-1][7:0] KW_TEXT = '{
    '{8'h69, 8'h6e, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // int
    '{8'h72, 8'h65, 8'h74, 8'h75, 8'h72, 8'h6e, 8'h00, 8'h00},  // return
    '{8'h76, 8'h6f, 8'h69, 8'h64, 8'h00, 8'h00, 8'h00, 8'h00},  // void
    '{8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // if
    '{8'h65, 8'h6c, 8'h73, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00},  // else
    '{8'h77, 8'h68, 8'h69, 8'h6c, 8'h65, 8'h00, 8'h00, 8'h00},  // while
    '{8'h66, 8'h6f, 8'h72, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // for
    '{8'h62, 8'h72, 8'h65, 8'h61, 8'h6b, 8'h00, 8'h00, 8'h00},  // break
    '{8'h63, 8'h6f, 8'h6e, 8'h74, 8'h69, 8'h6e, 8'h75, 8'h65}   // continue
  };
  localparam logic [0:KW_COUNT-1][7:0] KW_LEN = '{
    8'd3, 8'd6, 8'd4, 8'd2, 8'd4, 8'd5, 8'd3, 8'd5, 8'd8
  };

  // the include directive text
  localparam logic [0:PREFIX_CHARS-1][7:0] INCL_TEXT = '{
    8'h23, 8'h69, 8'h6e, 8'h63, 8'h6c, 8'h75, 8'h64, 8'h65
  };

  typedef logic [0:PREFIX_CHARS-1][7:0] prefix_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] char_code;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  token_class;
    logic [31:0] token_start;
    logic [7:0]  token_length;
    logic [7:0]  first_char;
    logic        too_long;
    logic        last;
  } out_beat_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_ident_char(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a)) ||
           (c == CH_UNDER);
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return (c == CH_LT) || (c == CH_GT) || (c == CH_LPAREN) || (c == CH_RPAREN) ||
           (c == CH_LBRACE) || (c == CH_RBRACE);
  endfunction

  function automatic logic is_sep(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR) ||
           (c == CH_SEMI) || (c == CH_LBRACK) || (c == CH_RBRACK);
  endfunction

  // parallel whole-token keyword match, only the first len characters count
  function automatic logic kw_match(input prefix_t pre, input logic [7:0] len);
    logic hit;
    logic eq;
    hit = 1'b0;
    for (int k = 0; k < KW_COUNT; k++) begin
      eq = (len == KW_LEN[k]);
      for (int j = 0; j < PREFIX_CHARS; j++) begin
        if (8'(j) < len) begin
          eq = eq && (pre[j] == KW_TEXT[k][j]);
        end
      end
      hit = hit | eq;
    end
    return hit;
  endfunction

endpackage

// ===== sv/c_source_tokenizer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_source_tokenizer_unit: streaming C tokenizer
// Takes one source character per beat and reports tokens as class, start
// offset, length, first character and overflow flag.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake            payload
//  in_      input      in_valid / in_stall  in_beat_t  (kind, char_code)
//  out_     output     out_valid/out_stall  out_beat_t (one token per beat)
//
// One character beat is taken per cycle; its zero, one or two tokens go into
// a four-entry result queue in that same cycle and leave at one per cycle.
// in_stall rises while the queue cannot take two more tokens, so the sustained
// rate is one beat per cycle as long as beats average at most one token.
// Synchronous active-low reset empties the queue and clears the held token.
// A stall on out_ only backs up the queue; held state is untouched.
module c_source_tokenizer_unit
  import cst_pkg::*;
#(
  parameter int MAX_TOKEN_CHARS = MAX_TOKEN_CHARS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  localparam int               Q_DEPTH = 4;
  localparam int               QP_W    = $clog2(Q_DEPTH);
  localparam logic [7:0]       MAX_LEN = 8'(MAX_TOKEN_CHARS);
  localparam logic [QP_W:0]    Q_ROOM  = (QP_W + 1)'(Q_DEPTH - 2);

  // held token state
  prefix_t     prefix_r, prefix_nxt;
  logic [7:0]  held_len_r, held_len_nxt;
  logic [31:0] held_start_r, held_start_nxt;
  logic [2:0]  held_class_r, held_class_nxt;
  logic [31:0] offset_r, offset_nxt;
  logic        ovf_r, ovf_nxt;

  // result queue
  out_beat_t       q_r [Q_DEPTH];
  logic [QP_W-1:0] head_r, tail_r;
  logic [QP_W:0]   count_r;

  logic       accept, pop;
  out_beat_t  res [2];
  logic [1:0] n_res;

  logic       incl;
  logic [7:0] len1;
  logic       ovf1;
  logic [2:0] cls1;
  logic [2:0] fin_cls;
  out_beat_t  flush_beat;
  logic [7:0] c;

  assign in_stall  = (count_r > Q_ROOM);
  assign accept    = in_valid && !in_stall;
  assign out_valid = (count_r != '0);
  assign out_data  = q_r[head_r];
  assign pop       = out_valid && !out_stall;

  // token assembly for one accepted beat
  always_comb begin
    c              = in_data.char_code;
    prefix_nxt     = prefix_r;
    held_len_nxt   = held_len_r;
    held_start_nxt = held_start_r;
    held_class_nxt = held_class_r;
    offset_nxt     = offset_r;
    ovf_nxt        = ovf_r;
    res[0]         = '0;
    res[1]         = '0;
    n_res          = 2'd0;

    incl    = (held_len_r == 8'd8) && (prefix_r == INCL_TEXT);
    fin_cls = kw_match(prefix_r, held_len_r) ? CLS_KEYWORD :
              (is_digit(prefix_r[0]) ? CLS_CONST : CLS_IDENT);

    flush_beat              = '0;
    flush_beat.token_start  = held_start_r;
    flush_beat.token_length = held_len_r;
    flush_beat.first_char   = prefix_r[0];
    flush_beat.too_long     = ovf_r;

    // held include goes out before the character is looked at
    len1 = incl ? 8'd0 : held_len_r;
    ovf1 = incl ? 1'b0 : ovf_r;
    cls1 = incl ? CLS_UNKNOWN : held_class_r;

    if (accept) begin
      if (in_data.kind == KIND_END) begin
        // end of stream: flush and restart offsets
        if (held_len_r != 8'd0) begin
          res[0]             = flush_beat;
          res[0].token_class = fin_cls;
          n_res              = 2'd1;
        end
        held_len_nxt   = 8'd0;
        ovf_nxt        = 1'b0;
        held_class_nxt = CLS_UNKNOWN;
        offset_nxt     = '0;
      end else begin
        if (incl) begin
          res[0]              = '0;
          res[0].token_class  = CLS_PREPROC;
          res[0].token_start  = held_start_r;
          res[0].token_length = 8'd8;
          res[0].first_char   = CH_HASH;
          n_res               = 2'd1;
        end

        priority if (c == CH_HASH) begin
          // flush and start a preprocessor token
          if (len1 != 8'd0) begin
            res[n_res[0]]             = flush_beat;
            res[n_res[0]].token_class = cls1;
            n_res                     = n_res + 2'd1;
          end
          held_class_nxt = CLS_PREPROC;
          held_start_nxt = offset_r;
          prefix_nxt[0]  = c;
          held_len_nxt   = 8'd1;
          ovf_nxt        = 1'b0;
        end else if (is_punct(c)) begin
          // flush with last class, then the punctuator
          if (len1 != 8'd0) begin
            res[n_res[0]]             = flush_beat;
            res[n_res[0]].token_class = cls1;
            n_res                     = n_res + 2'd1;
          end
          res[n_res[0]]              = '0;
          res[n_res[0]].token_class  = CLS_PUNCT;
          res[n_res[0]].token_start  = offset_r;
          res[n_res[0]].token_length = 8'd1;
          res[n_res[0]].first_char   = c;
          n_res                      = n_res + 2'd1;
          held_len_nxt               = 8'd0;
          ovf_nxt                    = 1'b0;
          held_class_nxt             = CLS_UNKNOWN;
        end else if (is_sep(c)) begin
          // flush reclassified, drop the separator
          if (len1 != 8'd0) begin
            res[n_res[0]]             = flush_beat;
            res[n_res[0]].token_class = fin_cls;
            n_res                     = n_res + 2'd1;
          end
          held_len_nxt   = 8'd0;
          ovf_nxt        = 1'b0;
          held_class_nxt = CLS_UNKNOWN;
        end else begin
          // append to the held token, saturating the length
          if (len1 == 8'd0) begin
            held_start_nxt = offset_r;
          end
          if (len1 < 8'(PREFIX_CHARS)) begin
            prefix_nxt[len1[2:0]] = c;
          end
          if (len1 < MAX_LEN) begin
            held_len_nxt = len1 + 8'd1;
            ovf_nxt      = ovf1;
          end else begin
            held_len_nxt = len1;
            ovf_nxt      = 1'b1;
          end
          if (is_ident_char(c)) begin
            held_class_nxt = CLS_IDENT;
          end else if (is_digit(c)) begin
            held_class_nxt = CLS_CONST;
          end else begin
            held_class_nxt = CLS_UNKNOWN;
          end
        end
        offset_nxt = offset_r + 32'd1;
      end

      // mark the final token of this beat
      if (n_res == 2'd2) begin
        res[1].last = 1'b1;
      end else if (n_res == 2'd1) begin
        res[0].last = 1'b1;
      end
    end
  end

  // held state
  always_ff @(posedge clk) begin
    prefix_r <= prefix_nxt;
    if (!rst_n) begin
      held_len_r   <= 8'd0;
      held_start_r <= '0;
      held_class_r <= CLS_UNKNOWN;
      offset_r     <= '0;
      ovf_r        <= 1'b0;
    end else begin
      held_len_r   <= held_len_nxt;
      held_start_r <= held_start_nxt;
      held_class_r <= held_class_nxt;
      offset_r     <= offset_nxt;
      ovf_r        <= ovf_nxt;
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (n_res != 2'd0) begin
      q_r[tail_r] <= res[0];
    end
    if (n_res == 2'd2) begin
      q_r[tail_r + QP_W'(1)] <= res[1];
    end
  end

  // result queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      tail_r  <= tail_r + QP_W'(n_res);
      if (pop) begin
        head_r <= head_r + QP_W'(1);
      end
      count_r <= count_r + (QP_W + 1)'(n_res) - (QP_W + 1)'(pop);
    end
  end

endmodule

// ===== sim/tb_c_source_tokenizer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_c_source_tokenizer_unit: self-checking bench for the source tokenizer
// Streams directed and random C-like text with end markers into the block,
// predicts every token in a cycle-free model and checks the result beats in
// order, with random idling on both channels and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_c_source_tokenizer_unit;
  import cst_pkg::*;

  localparam int MAX_TOK = MAX_TOKEN_CHARS_DEF;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;

  c_source_tokenizer_unit #(.MAX_TOKEN_CHARS(MAX_TOK)) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // token predictor state
  // ---------------------------------------------------------------------------
  string       kw_names [9] = '{"int", "return", "void", "if", "else", "while", "for",
                                "break", "continue"};
  logic [7:0]  held_chars [8];
  int unsigned held_len;
  logic [31:0] held_at;
  logic [2:0]  held_cls;
  logic [31:0] src_ofs;
  logic        held_ovf;
  out_beat_t   step_tokens[$];
  out_beat_t   token_q[$];

  in_beat_t    pending[$];
  int unsigned cyc = 0;
  int          stim_items = 0;
  int          beats_in = 0;
  int          tokens_seen = 0;
  int          errs = 0;
  int          cls_count [8];
  int          overlong_seen = 0;

  // separators that only end the held token
  function automatic logic is_blank(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR ||
           c == CH_SEMI || c == CH_LBRACK || c == CH_RBRACK;
  endfunction

  // whole-token compare of the held text
  function automatic logic held_is(input string s);
    if (held_len != s.len()) return 1'b0;
    for (int i = 0; i < s.len(); i++) begin
      if (held_chars[i] != s[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // class given to a token ended by a separator or end marker
  function automatic logic [2:0] settled_class();
    foreach (kw_names[k]) begin
      if (held_is(kw_names[k])) return CLS_KEYWORD;
    end
    if (held_chars[0] >= "0" && held_chars[0] <= "9") return CLS_CONST;
    return CLS_IDENT;
  endfunction

  function automatic void emit_token(input logic [2:0] cls, input logic [31:0] at,
                                     input logic [7:0] len, input logic [7:0] first,
                                     input logic ovf);
    out_beat_t t;
    t.token_class  = cls;
    t.token_start  = at;
    t.token_length = len;
    t.first_char   = first;
    t.too_long     = ovf;
    t.last         = 1'b0;
    step_tokens.push_back(t);
  endfunction

  function automatic void flush_held(input logic [2:0] cls);
    if (held_len > 0) begin
      emit_token(cls, held_at, 8'(held_len), held_chars[0], held_ovf);
      held_len = 0;
      held_ovf = 1'b0;
    end
  endfunction

  function automatic void append_char(input logic [7:0] c);
    if (held_len == 0) held_at = src_ofs;
    if (held_len < 8) held_chars[held_len] = c;
    if (held_len < MAX_TOK) held_len++;
    else held_ovf = 1'b1;
  endfunction

  function automatic void predictor_reset();
    foreach (held_chars[i]) held_chars[i] = 8'h00;
    held_len = 0;
    held_at  = '0;
    held_cls = CLS_UNKNOWN;
    src_ofs  = '0;
    held_ovf = 1'b0;
  endfunction

  // tokens caused by one accepted input beat, appended to token_q
  function automatic void tokenize_beat(input in_beat_t b);
    logic [7:0] c;
    c = b.char_code;
    step_tokens.delete();
    if (b.kind == KIND_END) begin
      flush_held(settled_class());
      src_ofs  = '0;
      held_cls = CLS_UNKNOWN;
      held_ovf = 1'b0;
    end else begin
      // a complete include directive leaves before the new character
      if (held_is("#include")) begin
        emit_token(CLS_PREPROC, held_at, 8'd8, CH_HASH, 1'b0);
        held_len = 0;
        held_ovf = 1'b0;
        held_cls = CLS_UNKNOWN;
      end
      case (c)
        CH_HASH: begin
          flush_held(held_cls);
          held_cls = CLS_PREPROC;
          append_char(c);
        end
        CH_LT, CH_GT, CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE: begin
          flush_held(held_cls);
          emit_token(CLS_PUNCT, src_ofs, 8'd1, c, 1'b0);
          held_cls = CLS_UNKNOWN;
        end
        default: begin
          if (is_blank(c)) begin
            flush_held(settled_class());
            held_cls = CLS_UNKNOWN;
          end else begin
            append_char(c);
            if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER)
              held_cls = CLS_IDENT;
            else if (c >= "0" && c <= "9")
              held_cls = CLS_CONST;
            else
              held_cls = CLS_UNKNOWN;
          end
        end
      endcase
      src_ofs = src_ofs + 32'd1;
    end
    if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last = 1'b1;
    foreach (step_tokens[i]) token_q.push_back(step_tokens[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------------------
  task automatic queue_char(input logic [7:0] c);
    in_beat_t b;
    b.kind      = KIND_CHAR;
    b.char_code = c;
    pending.push_back(b);
    stim_items++;
  endtask

  task automatic queue_end();
    in_beat_t b;
    b.kind      = KIND_END;
    b.char_code = 8'($urandom_range(0, 255));
    pending.push_back(b);
    stim_items++;
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) queue_char(s[i]);
  endtask

  function automatic logic [7:0] word_char(input logic lead);
    int r;
    r = $urandom_range(0, lead ? 52 : 62);
    if (r < 26) return 8'(8'h61 + r);
    if (r < 52) return 8'(8'h41 + r - 26);
    if (r == 52) return CH_UNDER;
    return 8'(8'h30 + r - 53);
  endfunction

  function automatic logic [7:0] pick_punct();
    case ($urandom_range(0, 5))
      0: return CH_LT;
      1: return CH_GT;
      2: return CH_LPAREN;
      3: return CH_RPAREN;
      4: return CH_LBRACE;
      default: return CH_RBRACE;
    endcase
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 6))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_LF;
      3: return CH_CR;
      4: return CH_SEMI;
      5: return CH_LBRACK;
      default: return CH_RBRACK;
    endcase
  endfunction

  task automatic queue_word(input int n);
    queue_char(word_char(1'b1));
    for (int i = 1; i < n; i++) queue_char(word_char(1'b0));
  endtask

  // one random fragment of source text
  task automatic queue_fragment();
    int    sel;
    string kw;
    sel = $urandom_range(0, 99);
    if (sel < 20) begin
      kw = kw_names[$urandom_range(0, 8)];
      case ($urandom_range(0, 5))
        0: queue_text(kw.substr(0, kw.len() - 2));
        1: begin
          queue_text(kw);
          queue_char(word_char(1'b0));
        end
        default: queue_text(kw);
      endcase
      if ($urandom_range(0, 3) != 0) queue_char(pick_blank());
      else queue_char(pick_punct());
    end else if (sel < 34) begin
      queue_word($urandom_range(1, 12));
    end else if (sel < 43) begin
      repeat ($urandom_range(1, 6)) queue_char(8'(8'h30 + $urandom_range(0, 9)));
    end else if (sel < 51) begin
      queue_text("#include");
    end else if (sel < 56) begin
      queue_char(CH_HASH);
      if ($urandom_range(0, 1) != 0) queue_word($urandom_range(1, 8));
    end else if (sel < 68) begin
      queue_char(pick_punct());
    end else if (sel < 78) begin
      queue_char(pick_blank());
    end else if (sel < 88) begin
      queue_char(8'($urandom_range(0, 255)));
    end else if (sel < 93) begin
      queue_end();
    end else if (sel < 94 && $urandom_range(0, 2) == 0) begin
      queue_word($urandom_range(120, 140));
    end else begin
      repeat ($urandom_range(1, 4)) queue_char(8'($urandom_range(8'h20, 8'h7e)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequencing, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    // directed: include before punctuator, include at end, digit lead,
    // byte zero and high byte, whitespace flush, end marker
    queue_text("#include(");
    queue_text("#include");
    queue_end();
    queue_text("7x;");
    queue_char(8'h00);
    queue_char(8'hff);
    queue_char(CH_TAB);
    queue_end();
    // one token past the length limit, then random text
    queue_word($urandom_range(MAX_TOK + 1, MAX_TOK + 3));
    queue_char(pick_blank());
    while (stim_items < 950) queue_fragment();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    while (pending.size() != 0 || in_valid) @(posedge clk);
    while (token_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("tb: %0d input beats, %0d tokens checked, %0d overlong, %0d mismatches",
             beats_in, tokens_seen, overlong_seen, errs);
    $display("tb: ident %0d keyword %0d const %0d punct %0d preproc %0d unknown %0d",
             cls_count[CLS_IDENT], cls_count[CLS_KEYWORD], cls_count[CLS_CONST],
             cls_count[CLS_PUNCT], cls_count[CLS_PREPROC], cls_count[CLS_UNKNOWN]);
    if (errs == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("tb: timeout, %0d tokens still expected", token_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  // cycle count; inside the calm window neither side idles at random
  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  function automatic logic calm_window();
    return cyc >= 400 && cyc < 700;
  endfunction

  // ---------------------------------------------------------------------------
  // input driver
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else if (!in_valid || !in_stall) begin
      if (pending.size() != 0 && (calm_window() || $urandom_range(0, 99) >= 26)) begin
        in_valid <= 1'b1;
        in_data  <= pending.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output receiver: random stalls plus one long hold-off
  // ---------------------------------------------------------------------------
  int  hold_left = 0;
  int  rx_seen_in = 0;
  logic hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (in_valid && !in_stall) rx_seen_in <= rx_seen_in + 1;
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (!hold_done && rx_seen_in >= 300) begin
        out_stall <= 1'b1;
        hold_left <= 60;
        hold_done <= 1'b1;
      end else begin
        out_stall <= !calm_window() && ($urandom_range(0, 99) < 26);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predict on accepted input, check accepted tokens in order
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_beat_t exp_tok;
    if (!rst_n) begin
      predictor_reset();
    end else begin
      if (in_valid && !in_stall) begin
        tokenize_beat(in_data);
        beats_in++;
      end
      if (out_valid && !out_stall) begin
        tokens_seen++;
        if (token_q.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("tb: unexpected token cls %0d start %0d len %0d",
                     out_data.token_class, out_data.token_start, out_data.token_length);
        end else begin
          exp_tok = token_q.pop_front();
          cls_count[exp_tok.token_class]++;
          if (exp_tok.too_long) overlong_seen++;
          if (out_data.token_class !== exp_tok.token_class ||
              out_data.token_start !== exp_tok.token_start ||
              out_data.token_length !== exp_tok.token_length ||
              out_data.first_char !== exp_tok.first_char ||
              out_data.too_long !== exp_tok.too_long ||
              out_data.last !== exp_tok.last) begin
            errs++;
            if (errs <= 10) begin
              $display("tb: token %0d mismatch", tokens_seen);
              $display("  exp cls %0d start %0d len %0d first %h long %b last %b",
                       exp_tok.token_class, exp_tok.token_start, exp_tok.token_length,
                       exp_tok.first_char, exp_tok.too_long, exp_tok.last);
              $display("  got cls %0d start %0d len %0d first %h long %b last %b",
                       out_data.token_class, out_data.token_start, out_data.token_length,
                       out_data.first_char, out_data.too_long, out_data.last);
            end
          end
        end
      end
    end
  end

endmodule
